// ===== src/sfr_pkg.sv =====
// Shared types and constants for the serial frame receiver.
// No dependencies; compiled first.
package sfr_pkg;

  localparam logic [7:0]  PREAMBLE      = 8'h7E;
  localparam logic [7:0]  FRAME_TYPE    = 8'h01;
  localparam logic [31:0] WINDOW_RESET  = 32'd1000000;
  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // config register indexes
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef enum logic [6:0] {
    PH_HUNT1   = 7'b0000001,
    PH_HUNT2   = 7'b0000010,
    PH_TYPE    = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_LEN_HI  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } res_t;

endpackage

// ===== src/sfr_if.sv =====
// Handshake channel interfaces for the serial frame receiver.
// Depends on nothing; compiled after sfr_pkg.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [1:0]  status;
  logic [15:0] frame_length;
  modport source (output valid, kind, payload_byte, payload_index, status, frame_length,
                  input ready);
  modport sink   (input valid, kind, payload_byte, payload_index, status, frame_length,
                  output ready);
endinterface

interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/serial_frame_receiver_with_timeout.sv =====
// Top level of the serial frame receiver: input register, parser, result register, config.
// Depends on sfr_pkg, sfr_if (channel interfaces) and sfr_parser.
//
// Accepts one beat per clock while item.ready is high (a received byte or a timer tick)
// and gives at most one result beat per input beat: a payload byte with its index, or a
// frame-finished beat carrying status (ok, bad checksum, too long, timeout) and the length
// of a good frame. Sustained rate is one beat per cycle while results are taken.
// A beat taken sits in the input register, the parser works on it, and its result, if any,
// is registered in the result register as the beat moves on. item.ready drops only
// while the result register holds a beat the sink has not taken and the input register
// is also full. There is no clearing pass after reset. Configuration writes are taken
// every cycle (cfg.ready is always high) and should be made only while the block is idle.
module serial_frame_receiver_with_timeout (
  input  logic  clk,
  input  logic  rst,
  sfr_in_if.sink     item,
  sfr_out_if.source  result,
  sfr_cfg_if.sink    cfg
);
  import sfr_pkg::*;

  // config registers
  logic [31:0] window_ticks;
  logic [15:0] max_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      max_length   <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW:  window_ticks <= cfg.data;
        REG_MAX_LEN: max_length   <= cfg.data[15:0];
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;

  // result register
  logic out_valid;
  res_t out_res;

  logic advance;   // the beat in the input register moves on this cycle
  logic has_res;
  res_t res;

  assign advance    = !out_valid || result.ready;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_op   <= item.op;
      s1_byte <= item.rx_byte;
    end
  end

  sfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_valid && advance),
    .op           (s1_op),
    .rx_byte      (s1_byte),
    .window_ticks (window_ticks),
    .max_length   (max_length),
    .has_res      (has_res),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && has_res) begin
      out_res <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_res.kind;
  assign result.payload_byte  = out_res.payload_byte;
  assign result.payload_index = out_res.payload_index;
  assign result.status        = out_res.status;
  assign result.frame_length  = out_res.frame_length;

endmodule

// ===== src/sfr_parser.sv =====
// Frame parse state and per-beat next-state / result logic.
// Depends on sfr_pkg.
module sfr_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,          // commit the presented beat
  input  logic          op,
  input  logic [7:0]    rx_byte,
  input  logic [31:0]   window_ticks,
  input  logic [15:0]   max_length,
  output logic          has_res,
  output sfr_pkg::res_t res
);
  import sfr_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  running_sum, running_sum_next;
  // never exceeds window_ticks while armed, so 32 bits suffice
  logic [31:0] elapsed_ticks, elapsed_ticks_next;

  logic [7:0]  sum_plus;
  logic [15:0] len_full;
  logic [15:0] pos_inc;

  assign sum_plus = running_sum + rx_byte;
  assign len_full = {rx_byte, declared_length[7:0]};
  assign pos_inc  = byte_position + 16'd1;

  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    byte_position_next   = byte_position;
    running_sum_next     = running_sum;
    elapsed_ticks_next   = elapsed_ticks;
    has_res              = 1'b0;
    res                  = '0;
    res.kind             = KIND_FRAME;

    if (op == OP_TICK) begin
      if (elapsed_ticks >= window_ticks) begin
        has_res    = 1'b1;
        res.status = ST_TIMEOUT;
      end else begin
        elapsed_ticks_next = elapsed_ticks + 32'd1;
      end
    end else begin
      unique case (phase)
        PH_HUNT2: begin
          phase_next = (rx_byte == PREAMBLE) ? PH_TYPE : PH_HUNT1;
        end
        PH_TYPE: begin
          running_sum_next = rx_byte;
          phase_next       = (rx_byte == FRAME_TYPE) ? PH_LEN_LO : PH_HUNT1;
        end
        PH_LEN_LO: begin
          running_sum_next     = sum_plus;
          declared_length_next = {8'd0, rx_byte};
          phase_next           = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          running_sum_next     = sum_plus;
          declared_length_next = len_full;
          byte_position_next   = '0;
          if (len_full > max_length) begin
            has_res    = 1'b1;
            res.status = ST_TOO_LONG;
          end else begin
            phase_next = (len_full != 16'd0) ? PH_PAYLOAD : PH_CHECK;
          end
        end
        PH_PAYLOAD: begin
          has_res            = 1'b1;
          res.kind           = KIND_DATA;
          res.payload_byte   = rx_byte;
          res.payload_index  = byte_position;
          running_sum_next   = sum_plus;
          byte_position_next = pos_inc;
          if (pos_inc == declared_length) phase_next = PH_CHECK;
        end
        PH_CHECK: begin
          has_res = 1'b1;
          if (sum_plus == 8'd0) begin
            res.status       = ST_OK;
            res.frame_length = declared_length;
          end else begin
            res.status = ST_BAD_SUM;
          end
        end
        default: begin
          // first preamble hunt; stray codes are treated the same way
          phase_next = (rx_byte == PREAMBLE) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end

    // any frame result re-arms the parser
    if (has_res && res.kind == KIND_FRAME) begin
      phase_next           = PH_HUNT1;
      declared_length_next = '0;
      byte_position_next   = '0;
      running_sum_next     = '0;
      elapsed_ticks_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT1;
      declared_length <= '0;
      byte_position   <= '0;
      running_sum     <= '0;
      elapsed_ticks   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      byte_position   <= byte_position_next;
      running_sum     <= running_sum_next;
      elapsed_ticks   <= elapsed_ticks_next;
    end
  end

endmodule

// ===== src/sfr_checker.sv =====
// Port-level checks for the serial frame receiver, attached by bind.
// Depends on sfr_pkg and the top level serial_frame_receiver_with_timeout.
module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  payload_byte,
  input logic [15:0] payload_index,
  input logic [1:0]  status,
  input logic [15:0] frame_length
);
  import sfr_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({kind, payload_byte, payload_index,
                                                      status, frame_length}))
    else $error("result beat changed while stalled");

  // input side only backs up behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_data_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> status == ST_OK && frame_length == 16'd0)
    else $error("payload beat carries frame status");

  a_frame_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FRAME |->
      payload_byte == 8'd0 && payload_index == 16'd0 &&
      (status == ST_OK || frame_length == 16'd0))
    else $error("malformed frame-finished beat");

endmodule

bind serial_frame_receiver_with_timeout sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (item.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .kind          (result.kind),
  .payload_byte  (result.payload_byte),
  .payload_index (result.payload_index),
  .status        (result.status),
  .frame_length  (result.frame_length)
);
